FILE: rtl/core/cnp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnp_pkg
// Widths, stage indexes, register codes and shared types of the capsule
// nearest point pipeline.
// ----------------------------------------------------------------------------
package cnp_pkg;

  localparam int COORD_W = 32;
  localparam int GUARD_W = 16;
  localparam int RAD_W   = COORD_W - 1;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int MAG_W   = COORD_W;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int DOT_W   = PROD_W + 1;
  localparam int HALF_W  = PROD_W / 2;
  localparam int PP_W    = MAG_W + HALF_W;
  localparam int MX_W    = MAG_W + RAD_W;
  localparam int RR_W    = 2 * RAD_W;

  localparam int DIV_Q  = COORD_W + 2;
  localparam int DIV_DW = DOT_W + 1;
  localparam int DIV_NW = DIV_DW + DIV_Q;
  localparam int SQ_NW  = PROD_W + 2 * GUARD_W;
  localparam int SQ_RW  = SQ_NW / 2;
  localparam int OFF_W  = DIV_Q + 1;
  localparam int SUM_W  = DIV_Q + 2;

  localparam int CFG_DW    = 32;
  localparam int CFG_AW    = 5;
  localparam int REG_IDX_W = CFG_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_START_X = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_START_Y = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_END_X   = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_END_Y   = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_RADIUS  = REG_IDX_W'(4);

  localparam int ST_D1  = 5;
  localparam int ST_A   = ST_D1 + DIV_Q + 1;
  localparam int ST_SQ  = ST_A + 4;
  localparam int ST_D2  = ST_SQ + SQ_RW + 1;
  localparam int ST_OUT = ST_D2 + DIV_Q + 1;
  localparam int NSTG   = ST_OUT + 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [DOT_W-1:0]   dot_t;

  typedef struct packed {
    coord_t            start_x;
    coord_t            start_y;
    coord_t            end_x;
    coord_t            end_y;
    logic [RAD_W-1:0]  radius;
  } cfg_t;

  typedef struct packed {
    coord_t px;
    coord_t py;
    logic   sel_start;
    logic   sel_end;
    logic   negx;
    logic   negy;
  } sb1_t;

  typedef struct packed {
    coord_t           px;
    coord_t           py;
    coord_t           ax;
    coord_t           ay;
    logic             in_cap;
    logic             zero;
    logic             negx;
    logic             negy;
    logic [MX_W-1:0]  mx;
    logic [MX_W-1:0]  my;
  } sb2_t;

  typedef struct packed {
    coord_t px;
    coord_t py;
    coord_t ax;
    coord_t ay;
    logic   in_cap;
    logic   zero;
    logic   negx;
    logic   negy;
  } sb3_t;

  function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
    logic ok;
    ok = (&v[SUM_W-1:COORD_W-1]) | ~(|v[SUM_W-1:COORD_W-1]);
    if (ok) begin
      return v[COORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/cnp_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnp_in_if
// Query point channel: valid/ready handshake with the query coordinates.
// ----------------------------------------------------------------------------
interface cnp_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cnp_pkg::COORD_W-1:0]    query_x;
  logic signed [cnp_pkg::COORD_W-1:0]    query_y;

  modport source (output valid, output query_x, output query_y, input ready);
  modport sink   (input valid, input query_x, input query_y, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/cnp_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnp_out_if
// Result channel: valid/ready handshake with the nearest point and flag.
// ----------------------------------------------------------------------------
interface cnp_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cnp_pkg::COORD_W-1:0]    nearest_x;
  logic signed [cnp_pkg::COORD_W-1:0]    nearest_y;
  logic                                  is_inside;

  modport source (output valid, output nearest_x, output nearest_y, output is_inside,
                  input ready);
  modport sink   (input valid, input nearest_x, input nearest_y, input is_inside,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/core/cnp_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnp_cfg
// APB register bank holding the bone end points and the capsule radius.
// ----------------------------------------------------------------------------
module cnp_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cnp_pkg::CFG_AW-1:0]    paddr,
  input  logic [cnp_pkg::CFG_DW-1:0]    pwdata,
  output logic [cnp_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready,
  output cnp_pkg::cfg_t                 cfg
);

  cnp_pkg::cfg_t                       cfg_r;
  logic [cnp_pkg::REG_IDX_W-1:0]       idx;
  logic                                wr;

  assign idx    = paddr[cnp_pkg::CFG_AW-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr) begin
      unique case (idx)
        cnp_pkg::REG_START_X: cfg_r.start_x <= pwdata[cnp_pkg::COORD_W-1:0];
        cnp_pkg::REG_START_Y: cfg_r.start_y <= pwdata[cnp_pkg::COORD_W-1:0];
        cnp_pkg::REG_END_X:   cfg_r.end_x   <= pwdata[cnp_pkg::COORD_W-1:0];
        cnp_pkg::REG_END_Y:   cfg_r.end_y   <= pwdata[cnp_pkg::COORD_W-1:0];
        cnp_pkg::REG_RADIUS:  cfg_r.radius  <= pwdata[cnp_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      cnp_pkg::REG_START_X: prdata = cfg_r.start_x;
      cnp_pkg::REG_START_Y: prdata = cfg_r.start_y;
      cnp_pkg::REG_END_X:   prdata = cfg_r.end_x;
      cnp_pkg::REG_END_Y:   prdata = cfg_r.end_y;
      cnp_pkg::REG_RADIUS:  prdata = cnp_pkg::CFG_DW'(cfg_r.radius);
      default:              prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/cnp_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnp_div
// Pipelined restoring divider, one quotient bit per stage, advancing on en.
// ----------------------------------------------------------------------------
module cnp_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [cnp_pkg::DIV_NW-1:0]    num,
  input  logic [cnp_pkg::DIV_DW-1:0]    den,
  output logic [cnp_pkg::DIV_Q-1:0]     quo
);

  logic [cnp_pkg::DIV_NW-1:0] rem_r [cnp_pkg::DIV_Q];
  logic [cnp_pkg::DIV_DW-1:0] den_r [cnp_pkg::DIV_Q];
  logic [cnp_pkg::DIV_Q-1:0]  quo_r [cnp_pkg::DIV_Q];

  genvar k;
  generate
    for (k = 0; k < cnp_pkg::DIV_Q; k++) begin : g_stage
      localparam int B = cnp_pkg::DIV_Q - 1 - k;
      logic [cnp_pkg::DIV_NW-1:0] rin;
      logic [cnp_pkg::DIV_DW-1:0] din;
      logic [cnp_pkg::DIV_Q-1:0]  qin;
      logic [cnp_pkg::DIV_NW-1:0] dsh;
      logic                       ge;

      if (k == 0) begin : g_first
        assign rin = num;
        assign din = den;
        assign qin = '0;
      end else begin : g_next
        assign rin = rem_r[k-1];
        assign din = den_r[k-1];
        assign qin = quo_r[k-1];
      end

      assign dsh = cnp_pkg::DIV_NW'(din) << B;
      assign ge  = rin >= dsh;

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? rin - dsh : rin;
          den_r[k] <= din;
          quo_r[k] <= qin | (cnp_pkg::DIV_Q'(ge) << B);
        end
      end
    end
  endgenerate

  assign quo = quo_r[cnp_pkg::DIV_Q-1];

endmodule
`default_nettype wire

FILE: rtl/core/cnp_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnp_sqrt
// Pipelined integer square root, one root bit per stage, advancing on en.
// ----------------------------------------------------------------------------
module cnp_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [cnp_pkg::SQ_NW-1:0]     rad,
  output logic [cnp_pkg::SQ_RW-1:0]     root
);

  localparam int TW = cnp_pkg::SQ_NW + 1;

  logic [cnp_pkg::SQ_NW-1:0] rem_r [cnp_pkg::SQ_RW];
  logic [cnp_pkg::SQ_RW-1:0] res_r [cnp_pkg::SQ_RW];

  genvar k;
  generate
    for (k = 0; k < cnp_pkg::SQ_RW; k++) begin : g_stage
      localparam int B = cnp_pkg::SQ_RW - 1 - k;
      logic [cnp_pkg::SQ_NW-1:0] rin;
      logic [cnp_pkg::SQ_RW-1:0] qin;
      logic [TW-1:0]             trial;
      logic [TW-1:0]             diff;
      logic                      ge;

      if (k == 0) begin : g_first
        assign rin = rad;
        assign qin = '0;
      end else begin : g_next
        assign rin = rem_r[k-1];
        assign qin = res_r[k-1];
      end

      assign trial = (TW'(qin) << (B + 1)) + (TW'(1) << (2 * B));
      assign ge    = TW'(rin) >= trial;
      assign diff  = TW'(rin) - trial;

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? diff[cnp_pkg::SQ_NW-1:0] : rin;
          res_r[k] <= qin | (cnp_pkg::SQ_RW'(ge) << B);
        end
      end
    end
  endgenerate

  assign root = res_r[cnp_pkg::SQ_RW-1];

endmodule
`default_nettype wire

FILE: rtl/core/capsule_nearest_point_2d_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// capsule_nearest_point_2d_top
// Nearest point of a 2D capsule (bone plus radius) to a stream of queries.
//
//   port group   direction  handshake              payload
//   in_if        in         valid/ready            query_x, query_y
//   out_if       out        valid/ready            nearest_x, nearest_y, is_inside
//   cfg_*        in         APB write, pready = 1  bone ends, capsule radius
//
// One transaction per cycle unless the output stalls; the path from input to
// output register runs through the two quotient dividers and the root
// extractor, one bit per stage each. The whole pipe holds while a result
// waits at the output; the entry stage still fills when empty. Reset clears
// valid bits and the register bank only.
// ----------------------------------------------------------------------------
module capsule_nearest_point_2d_top (
  input  logic                          clk,
  input  logic                          rst_n,
  cnp_in_if.sink                        in_if,
  cnp_out_if.source                     out_if,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [cnp_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [cnp_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [cnp_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  cnp_pkg::cfg_t   cfg;
  cnp_pkg::coord_t sx, sy, ex, ey;
  logic [cnp_pkg::RAD_W-1:0] rad;

  cnp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign sx  = cfg.start_x;
  assign sy  = cfg.start_y;
  assign ex  = cfg.end_x;
  assign ey  = cfg.end_y;
  assign rad = cfg.radius;

  // valid chain and flow control
  logic [cnp_pkg::NSTG-1:0] vld_r;
  logic en, ld0;

  assign en          = ~vld_r[cnp_pkg::ST_OUT] | out_if.ready;
  assign ld0         = en | ~vld_r[0];
  assign in_if.ready = ld0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld0) vld_r[0] <= in_if.valid;
      if (en)  vld_r[cnp_pkg::NSTG-1:1] <= vld_r[cnp_pkg::NSTG-2:0];
    end
  end

  // entry
  cnp_pkg::coord_t p0x_r, p0y_r;
  always_ff @(posedge clk) begin
    if (ld0) begin
      p0x_r <= in_if.query_x;
      p0y_r <= in_if.query_y;
    end
  end

  // front: differences, products, dots, partial products
  cnp_pkg::coord_t p1x_r, p1y_r, p2x_r, p2y_r, p3x_r, p3y_r, p4x_r, p4y_r;
  cnp_pkg::diff_t  ps1x_r, ps1y_r, d1x_r, d1y_r;
  cnp_pkg::prod_t  dd2x_r, dd2y_r, ds2x_r, ds2y_r;
  logic [cnp_pkg::MAG_W-1:0] ad2x_r, ad2y_r, ad3x_r, ad3y_r;
  logic ng2x_r, ng2y_r, ng3x_r, ng3y_r, ng4x_r, ng4y_r;
  cnp_pkg::dot_t   dd3_r, ds3_r;
  logic [cnp_pkg::PROD_W-1:0] dd4_r;
  logic [cnp_pkg::PP_W-1:0]   plo4x_r, phi4x_r, plo4y_r, phi4y_r;
  logic sst4_r, sen4_r;
  cnp_pkg::diff_t  ad2x_nxt, ad2y_nxt;

  assign ad2x_nxt = d1x_r[cnp_pkg::DIFF_W-1] ? -d1x_r : d1x_r;
  assign ad2y_nxt = d1y_r[cnp_pkg::DIFF_W-1] ? -d1y_r : d1y_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p1x_r  <= p0x_r;
      p1y_r  <= p0y_r;
      ps1x_r <= cnp_pkg::diff_t'(p0x_r) - cnp_pkg::diff_t'(sx);
      ps1y_r <= cnp_pkg::diff_t'(p0y_r) - cnp_pkg::diff_t'(sy);
      d1x_r  <= cnp_pkg::diff_t'(ex) - cnp_pkg::diff_t'(sx);
      d1y_r  <= cnp_pkg::diff_t'(ey) - cnp_pkg::diff_t'(sy);

      p2x_r  <= p1x_r;
      p2y_r  <= p1y_r;
      dd2x_r <= cnp_pkg::prod_t'(d1x_r) * cnp_pkg::prod_t'(d1x_r);
      dd2y_r <= cnp_pkg::prod_t'(d1y_r) * cnp_pkg::prod_t'(d1y_r);
      ds2x_r <= cnp_pkg::prod_t'(d1x_r) * cnp_pkg::prod_t'(ps1x_r);
      ds2y_r <= cnp_pkg::prod_t'(d1y_r) * cnp_pkg::prod_t'(ps1y_r);
      ad2x_r <= ad2x_nxt[cnp_pkg::MAG_W-1:0];
      ad2y_r <= ad2y_nxt[cnp_pkg::MAG_W-1:0];
      ng2x_r <= d1x_r[cnp_pkg::DIFF_W-1];
      ng2y_r <= d1y_r[cnp_pkg::DIFF_W-1];

      p3x_r  <= p2x_r;
      p3y_r  <= p2y_r;
      dd3_r  <= cnp_pkg::dot_t'(dd2x_r) + cnp_pkg::dot_t'(dd2y_r);
      ds3_r  <= cnp_pkg::dot_t'(ds2x_r) + cnp_pkg::dot_t'(ds2y_r);
      ad3x_r <= ad2x_r;
      ad3y_r <= ad2y_r;
      ng3x_r <= ng2x_r;
      ng3y_r <= ng2y_r;

      p4x_r   <= p3x_r;
      p4y_r   <= p3y_r;
      sst4_r  <= (dd3_r == '0) | ds3_r[cnp_pkg::DOT_W-1];
      sen4_r  <= ds3_r > dd3_r;
      dd4_r   <= dd3_r[cnp_pkg::PROD_W-1:0];
      plo4x_r <= cnp_pkg::PP_W'(ad3x_r) * cnp_pkg::PP_W'(ds3_r[cnp_pkg::HALF_W-1:0]);
      phi4x_r <= cnp_pkg::PP_W'(ad3x_r)
                 * cnp_pkg::PP_W'(ds3_r[cnp_pkg::PROD_W-1:cnp_pkg::HALF_W]);
      plo4y_r <= cnp_pkg::PP_W'(ad3y_r) * cnp_pkg::PP_W'(ds3_r[cnp_pkg::HALF_W-1:0]);
      phi4y_r <= cnp_pkg::PP_W'(ad3y_r)
                 * cnp_pkg::PP_W'(ds3_r[cnp_pkg::PROD_W-1:cnp_pkg::HALF_W]);
      ng4x_r  <= ng3x_r;
      ng4y_r  <= ng3y_r;
    end
  end

  // bone projection divide
  logic [cnp_pkg::DIV_NW-1:0] num5x_r, num5y_r;
  logic [cnp_pkg::DIV_DW-1:0] den5_r;
  cnp_pkg::sb1_t              sb5_r;
  cnp_pkg::sb1_t              sb1_r [cnp_pkg::DIV_Q];
  logic [cnp_pkg::DIV_Q-1:0]  q1x, q1y;

  always_ff @(posedge clk) begin
    if (en) begin
      num5x_r <= (cnp_pkg::DIV_NW'(phi4x_r) << (cnp_pkg::HALF_W + 1))
               + (cnp_pkg::DIV_NW'(plo4x_r) << 1) + cnp_pkg::DIV_NW'(dd4_r);
      num5y_r <= (cnp_pkg::DIV_NW'(phi4y_r) << (cnp_pkg::HALF_W + 1))
               + (cnp_pkg::DIV_NW'(plo4y_r) << 1) + cnp_pkg::DIV_NW'(dd4_r);
      den5_r  <= cnp_pkg::DIV_DW'(dd4_r) << 1;
      sb5_r   <= '{px: p4x_r, py: p4y_r, sel_start: sst4_r, sel_end: sen4_r,
                   negx: ng4x_r, negy: ng4y_r};
      sb1_r[0] <= sb5_r;
      for (int k = 1; k < cnp_pkg::DIV_Q; k++) sb1_r[k] <= sb1_r[k-1];
    end
  end

  cnp_div u_div1x (.clk(clk), .en(en), .num(num5x_r), .den(den5_r), .quo(q1x));
  cnp_div u_div1y (.clk(clk), .en(en), .num(num5y_r), .den(den5_r), .quo(q1y));

  // anchor selection and offset vector
  cnp_pkg::sb1_t sba;
  logic signed [cnp_pkg::OFF_W-1:0] offx, offy;
  logic signed [cnp_pkg::SUM_W-1:0] midx, midy;
  cnp_pkg::coord_t ax_nxt, ay_nxt;

  assign sba  = sb1_r[cnp_pkg::DIV_Q-1];
  assign offx = sba.negx ? -cnp_pkg::OFF_W'(q1x) : cnp_pkg::OFF_W'(q1x);
  assign offy = sba.negy ? -cnp_pkg::OFF_W'(q1y) : cnp_pkg::OFF_W'(q1y);
  assign midx = cnp_pkg::SUM_W'(sx) + cnp_pkg::SUM_W'(offx);
  assign midy = cnp_pkg::SUM_W'(sy) + cnp_pkg::SUM_W'(offy);

  always_comb begin
    if (sba.sel_start) begin
      ax_nxt = sx;
      ay_nxt = sy;
    end else if (sba.sel_end) begin
      ax_nxt = ex;
      ay_nxt = ey;
    end else begin
      ax_nxt = midx[cnp_pkg::COORD_W-1:0];
      ay_nxt = midy[cnp_pkg::COORD_W-1:0];
    end
  end

  cnp_pkg::coord_t pAx_r, pAy_r, aAx_r, aAy_r;
  cnp_pkg::coord_t pVx_r, pVy_r, aVx_r, aVy_r;
  cnp_pkg::coord_t pW_x_r, pW_y_r, aW_x_r, aW_y_r;
  cnp_pkg::coord_t pZx_r, pZy_r, aZx_r, aZy_r;
  cnp_pkg::diff_t  vx_r, vy_r, av_x_nxt, av_y_nxt;
  cnp_pkg::prod_t  sqx_r, sqy_r;
  logic [cnp_pkg::MAG_W-1:0]  avx_r, avy_r;
  logic ngWx_r, ngWy_r, ngZx_r, ngZy_r;
  logic [cnp_pkg::RR_W-1:0]   rrW_r, rrZ_r;
  logic [cnp_pkg::PROD_W-1:0] vvZ_r;
  logic [cnp_pkg::MX_W-1:0]   mxZ_r, myZ_r;
  logic [cnp_pkg::SQ_NW-1:0]  sqn_r;
  cnp_pkg::sb2_t              sv4_r;
  cnp_pkg::sb2_t              sb2_r [cnp_pkg::SQ_RW];

  assign av_x_nxt = vx_r[cnp_pkg::DIFF_W-1] ? -vx_r : vx_r;
  assign av_y_nxt = vy_r[cnp_pkg::DIFF_W-1] ? -vy_r : vy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pAx_r <= sba.px;
      pAy_r <= sba.py;
      aAx_r <= ax_nxt;
      aAy_r <= ay_nxt;

      pVx_r <= pAx_r;
      pVy_r <= pAy_r;
      aVx_r <= aAx_r;
      aVy_r <= aAy_r;
      vx_r  <= cnp_pkg::diff_t'(pAx_r) - cnp_pkg::diff_t'(aAx_r);
      vy_r  <= cnp_pkg::diff_t'(pAy_r) - cnp_pkg::diff_t'(aAy_r);

      pW_x_r <= pVx_r;
      pW_y_r <= pVy_r;
      aW_x_r <= aVx_r;
      aW_y_r <= aVy_r;
      sqx_r  <= cnp_pkg::prod_t'(vx_r) * cnp_pkg::prod_t'(vx_r);
      sqy_r  <= cnp_pkg::prod_t'(vy_r) * cnp_pkg::prod_t'(vy_r);
      avx_r  <= av_x_nxt[cnp_pkg::MAG_W-1:0];
      avy_r  <= av_y_nxt[cnp_pkg::MAG_W-1:0];
      ngWx_r <= vx_r[cnp_pkg::DIFF_W-1];
      ngWy_r <= vy_r[cnp_pkg::DIFF_W-1];
      rrW_r  <= cnp_pkg::RR_W'(rad) * cnp_pkg::RR_W'(rad);

      pZx_r  <= pW_x_r;
      pZy_r  <= pW_y_r;
      aZx_r  <= aW_x_r;
      aZy_r  <= aW_y_r;
      vvZ_r  <= cnp_pkg::PROD_W'(sqx_r) + cnp_pkg::PROD_W'(sqy_r);
      mxZ_r  <= cnp_pkg::MX_W'(avx_r) * cnp_pkg::MX_W'(rad);
      myZ_r  <= cnp_pkg::MX_W'(avy_r) * cnp_pkg::MX_W'(rad);
      ngZx_r <= ngWx_r;
      ngZy_r <= ngWy_r;
      rrZ_r  <= rrW_r;

      sqn_r <= cnp_pkg::SQ_NW'(vvZ_r) << (2 * cnp_pkg::GUARD_W);
      sv4_r <= '{px: pZx_r, py: pZy_r, ax: aZx_r, ay: aZy_r,
                 in_cap: vvZ_r < cnp_pkg::PROD_W'(rrZ_r), zero: vvZ_r == '0,
                 negx: ngZx_r, negy: ngZy_r, mx: mxZ_r, my: myZ_r};
      sb2_r[0] <= sv4_r;
      for (int k = 1; k < cnp_pkg::SQ_RW; k++) sb2_r[k] <= sb2_r[k-1];
    end
  end

  // length and radius scaling divide
  logic [cnp_pkg::SQ_RW-1:0]  len;
  cnp_pkg::sb2_t              sbl;
  logic [cnp_pkg::DIV_NW-1:0] num2x_r, num2y_r;
  logic [cnp_pkg::DIV_DW-1:0] den2_r;
  cnp_pkg::sb3_t              sn2_r;
  cnp_pkg::sb3_t              sb3_r [cnp_pkg::DIV_Q];
  logic [cnp_pkg::DIV_Q-1:0]  q2x, q2y;

  cnp_sqrt u_sqrt (.clk(clk), .en(en), .rad(sqn_r), .root(len));

  assign sbl = sb2_r[cnp_pkg::SQ_RW-1];

  always_ff @(posedge clk) begin
    if (en) begin
      num2x_r <= (cnp_pkg::DIV_NW'(sbl.mx) << (cnp_pkg::GUARD_W + 1))
               + cnp_pkg::DIV_NW'(len);
      num2y_r <= (cnp_pkg::DIV_NW'(sbl.my) << (cnp_pkg::GUARD_W + 1))
               + cnp_pkg::DIV_NW'(len);
      den2_r  <= cnp_pkg::DIV_DW'(len) << 1;
      sn2_r   <= '{px: sbl.px, py: sbl.py, ax: sbl.ax, ay: sbl.ay,
                   in_cap: sbl.in_cap, zero: sbl.zero, negx: sbl.negx, negy: sbl.negy};
      sb3_r[0] <= sn2_r;
      for (int k = 1; k < cnp_pkg::DIV_Q; k++) sb3_r[k] <= sb3_r[k-1];
    end
  end

  cnp_div u_div2x (.clk(clk), .en(en), .num(num2x_r), .den(den2_r), .quo(q2x));
  cnp_div u_div2y (.clk(clk), .en(en), .num(num2y_r), .den(den2_r), .quo(q2y));

  // result select and output register
  cnp_pkg::sb3_t sbo;
  logic signed [cnp_pkg::OFF_W-1:0] cx, cy;
  logic signed [cnp_pkg::SUM_W-1:0] rx, ry;
  cnp_pkg::coord_t nx_nxt, ny_nxt, nx_r, ny_r;
  logic ins_r;

  assign sbo = sb3_r[cnp_pkg::DIV_Q-1];
  assign cx  = sbo.negx ? -cnp_pkg::OFF_W'(q2x) : cnp_pkg::OFF_W'(q2x);
  assign cy  = sbo.negy ? -cnp_pkg::OFF_W'(q2y) : cnp_pkg::OFF_W'(q2y);
  assign rx  = cnp_pkg::SUM_W'(sbo.ax) + cnp_pkg::SUM_W'(cx);
  assign ry  = cnp_pkg::SUM_W'(sbo.ay) + cnp_pkg::SUM_W'(cy);

  always_comb begin
    if (sbo.in_cap) begin
      nx_nxt = sbo.px;
      ny_nxt = sbo.py;
    end else if (sbo.zero) begin
      nx_nxt = sbo.ax;
      ny_nxt = sbo.ay;
    end else begin
      nx_nxt = cnp_pkg::sat_coord(rx);
      ny_nxt = cnp_pkg::sat_coord(ry);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r  <= nx_nxt;
      ny_r  <= ny_nxt;
      ins_r <= sbo.in_cap;
    end
  end

  assign out_if.valid     = vld_r[cnp_pkg::ST_OUT];
  assign out_if.nearest_x = nx_r;
  assign out_if.nearest_y = ny_r;
  assign out_if.is_inside = ins_r;

  // checks
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r[cnp_pkg::NSTG-1:1]))
    else $error("pipeline moved while stalled");

  a_entry_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> vld_r[0] && vld_r[cnp_pkg::ST_OUT])
    else $error("entry blocked without a full stage and a waiting result");

  a_zero_inside: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[cnp_pkg::ST_SQ] && sv4_r.in_cap && sv4_r.zero |-> rad != '0)
    else $error("zero offset flagged inside with zero radius");

endmodule
`default_nettype wire

FILE: tb/sv/tb_capsule_nearest_point_2d_top.sv
// ----------------------------------------------------------------------------
// tb_capsule_nearest_point_2d_top
// Self-checking bench for the capsule nearest point pipeline. Writes a series
// of capsules over the APB port, streams query points with random gaps and
// output stalls, and compares every result against a wide-integer predictor.
// ----------------------------------------------------------------------------
module tb_capsule_nearest_point_2d_top;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    cnp_pkg::coord_t x;
    cnp_pkg::coord_t y;
    logic            in_cap;
  } nearest_t;

  typedef struct {
    cnp_pkg::coord_t qx;
    cnp_pkg::coord_t qy;
    nearest_t        at_reset;
  } query_row_t;

  localparam int F = 65536;
  localparam cnp_pkg::coord_t CMIN = 32'sh8000_0000;
  localparam cnp_pkg::coord_t CMAX = 32'sh7fff_ffff;
  localparam int N_RAND_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 160;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [cnp_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [cnp_pkg::CFG_DW-1:0] cfg_pwdata = '0;
  logic [cnp_pkg::CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  cnp_in_if  in_ch();
  cnp_out_if out_ch();

  capsule_nearest_point_2d_top DUT (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #10 clk = ~clk;

  cnp_pkg::coord_t cap_sx = '0, cap_sy = '0, cap_ex = '0, cap_ey = '0;
  logic [cnp_pkg::RAD_W-1:0] cap_r = '0;

  nearest_t expected_q[$];
  int errors = 0;
  int n_queries = 0;
  int n_results = 0;
  bit rx_stall_on = 1'b0;
  bit tx_gaps_on = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int gap_left = 0;

  function automatic wide_t round_div(wide_t num, wide_t den);
    wide_t n, q;
    n = (num < 0) ? -num : num;
    q = (2 * n + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic wide_t int_sqrt(wide_t n);
    wide_t res, bitv;
    res = 0;
    bitv = wide_t'(1) <<< 254;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  function automatic cnp_pkg::coord_t clamp_coord(wide_t v);
    if (v > wide_t'(CMAX)) return CMAX;
    if (v < wide_t'(CMIN)) return CMIN;
    return v[cnp_pkg::COORD_W-1:0];
  endfunction

  function automatic nearest_t predict_nearest(cnp_pkg::coord_t qx, cnp_pkg::coord_t qy);
    wide_t px, py, sx, sy, ex, ey, r, dx, dy, dd, ds, de, ax, ay, vx, vy, vv, len, scale;
    nearest_t res;
    px = qx; py = qy; sx = cap_sx; sy = cap_sy; ex = cap_ex; ey = cap_ey;
    r = wide_t'(cap_r);
    dx = ex - sx; dy = ey - sy;
    dd = dx * dx + dy * dy;
    ds = dx * (px - sx) + dy * (py - sy);
    de = ds - dd;
    if (dd == 0 || ds < 0) begin
      ax = sx; ay = sy;
    end else if (de > 0) begin
      ax = ex; ay = ey;
    end else begin
      ax = sx + round_div(dx * ds, dd);
      ay = sy + round_div(dy * ds, dd);
    end
    vx = px - ax; vy = py - ay;
    vv = vx * vx + vy * vy;
    res.in_cap = (vv < r * r);
    if (res.in_cap) begin
      res.x = clamp_coord(px); res.y = clamp_coord(py);
    end else if (vx == 0 && vy == 0) begin
      res.x = clamp_coord(ax); res.y = clamp_coord(ay);
    end else begin
      len = int_sqrt(vv <<< (2 * cnp_pkg::GUARD_W));
      scale = r <<< cnp_pkg::GUARD_W;
      res.x = clamp_coord(ax + round_div(vx * scale, len));
      res.y = clamp_coord(ay + round_div(vy * scale, len));
    end
    return res;
  endfunction

  task automatic write_reg(logic [cnp_pkg::REG_IDX_W-1:0] idx,
                           logic [cnp_pkg::CFG_DW-1:0] val);
    @(negedge clk);
    cfg_psel = 1'b1; cfg_pwrite = 1'b1; cfg_penable = 1'b0;
    cfg_paddr = {idx, 2'b00}; cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      cnp_pkg::REG_START_X: cap_sx = val;
      cnp_pkg::REG_START_Y: cap_sy = val;
      cnp_pkg::REG_END_X:   cap_ex = val;
      cnp_pkg::REG_END_Y:   cap_ey = val;
      cnp_pkg::REG_RADIUS:  cap_r = val[cnp_pkg::RAD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
  endtask

  task automatic set_capsule(cnp_pkg::coord_t sx, cnp_pkg::coord_t sy,
                             cnp_pkg::coord_t ex, cnp_pkg::coord_t ey,
                             logic [cnp_pkg::CFG_DW-1:0] r);
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    write_reg(cnp_pkg::REG_START_X, sx);
    write_reg(cnp_pkg::REG_START_Y, sy);
    write_reg(cnp_pkg::REG_END_X, ex);
    write_reg(cnp_pkg::REG_END_Y, ey);
    write_reg(cnp_pkg::REG_RADIUS, r);
  endtask

  // Drive at the falling edge, accept at the rising edge.
  task automatic send_query(cnp_pkg::coord_t qx, cnp_pkg::coord_t qy);
    int gap;
    @(negedge clk);
    in_ch.valid = 1'b1; in_ch.query_x = qx; in_ch.query_y = qy;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q.push_back(predict_nearest(qx, qy));
    n_queries++;
    gap = 0;
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      in_ch.query_x = $urandom; in_ch.query_y = $urandom;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.query_x = '0; in_ch.query_y = '0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready = 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
      if (rx_stall_on && $urandom_range(0, 4) == 0) begin
        gap_left = ($urandom_range(0, 12) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk) begin
    nearest_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $error("unexpected transaction: nearest_x=%0d nearest_y=%0d is_inside=%0b",
               out_ch.nearest_x, out_ch.nearest_y, out_ch.is_inside);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_ch.nearest_x !== want.x) begin
          $error("nearest_x: expected %0d, got %0d", want.x, out_ch.nearest_x);
          errors++;
        end
        if (out_ch.nearest_y !== want.y) begin
          $error("nearest_y: expected %0d, got %0d", want.y, out_ch.nearest_y);
          errors++;
        end
        if (out_ch.is_inside !== want.in_cap) begin
          $error("is_inside: expected %0b, got %0b", want.in_cap, out_ch.is_inside);
          errors++;
        end
      end
    end
  end

  initial begin
    #80_000_000;
    $display("tb_capsule_nearest_point_2d_top NOT OK");
    $finish;
  end

  query_row_t directed[] = '{
    '{CMIN, CMIN, '{0, 0, 0}},
    '{CMAX, CMAX, '{0, 0, 0}},
    '{CMIN, CMAX, '{0, 0, 0}},
    '{CMAX, CMIN, '{0, 0, 0}},
    '{0, 0, '{0, 0, 0}},
    '{1, -1, '{0, 0, 0}},
    '{-5 * F, 0, '{0, 0, 0}},
    '{-3 * F, 4 * F, '{0, 0, 0}},
    '{15 * F, 0, '{0, 0, 0}},
    '{13 * F, -4 * F, '{0, 0, 0}},
    '{5 * F, F, '{0, 0, 0}},
    '{5 * F, 5 * F, '{0, 0, 0}},
    '{5 * F, -5 * F, '{0, 0, 0}},
    '{5 * F, 2 * F, '{0, 0, 0}},
    '{0, 2 * F, '{0, 0, 0}},
    '{10 * F, 0, '{0, 0, 0}},
    '{F / 2, F / 4, '{0, 0, 0}},
    '{7 * F + 1, -3 * F - 1, '{0, 0, 0}},
    '{-1, -1, '{0, 0, 0}},
    '{10 * F + 1, 2 * F, '{0, 0, 0}}
  };

  task automatic random_phase(int n);
    longint span, bx, by;
    cnp_pkg::coord_t qx, qy;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          qx = $urandom; qy = $urandom;
        end
        2: begin
          if ($urandom_range(0, 1)) begin
            qx = cap_sx; qy = cap_sy;
          end else begin
            qx = cap_ex; qy = cap_ey;
          end
        end
        default: begin
          span = longint'(cap_r) + 4 * F;
          case ($urandom_range(0, 2))
            0: begin bx = cap_sx; by = cap_sy; end
            1: begin bx = cap_ex; by = cap_ey; end
            default: begin
              bx = (longint'(cap_sx) + longint'(cap_ex)) / 2;
              by = (longint'(cap_sy) + longint'(cap_ey)) / 2;
            end
          endcase
          qx = cnp_pkg::coord_t'(bx + longint'($urandom_range(0, 32'hffff_ffff))
                                 % (2 * span + 1) - span);
          qy = cnp_pkg::coord_t'(by + longint'($urandom_range(0, 32'hffff_ffff))
                                 % (2 * span + 1) - span);
        end
      endcase
      send_query(qx, qy);
    end
  endtask

  initial begin
    cnp_pkg::coord_t sx, sy, ex, ey;
    logic [cnp_pkg::CFG_DW-1:0] r;
    int lim;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset capsule is a zero circle at the origin: every answer is the origin.
    foreach (directed[i]) begin
      send_query(directed[i].qx, directed[i].qy);
      if (expected_q[$] != directed[i].at_reset) begin
        $error("reset-capsule row %0d: predictor disagrees with table", i);
        errors++;
      end
    end

    set_capsule(0, 0, 10 * F, 0, 2 * F);
    rx_stall_on = 1'b1;
    foreach (directed[i]) send_query(directed[i].qx, directed[i].qy);

    for (int ph = 0; ph < N_RAND_PHASES; ph++) begin
      case (ph)
        0: begin sx = CMIN; sy = CMIN; ex = CMAX; ey = CMAX; r = 32'h7fff_ffff; end
        1: begin sx = CMAX; sy = CMIN; ex = CMIN; ey = CMAX; r = 0; end
        2: begin sx = 3 * F; sy = -2 * F; ex = 3 * F; ey = -2 * F; r = 5 * F; end
        3: begin sx = -F; sy = F; ex = 20 * F; ey = 9 * F; r = 0; end
        4: begin sx = CMAX; sy = CMAX; ex = CMAX - 5; ey = CMAX; r = 32'h7fff_ffff; end
        default: begin
          if (ph % 2 == 0) begin
            sx = $urandom; sy = $urandom; ex = $urandom; ey = $urandom; r = $urandom;
          end else begin
            sx = $signed($urandom_range(0, 400 * F)) - 200 * F;
            sy = $signed($urandom_range(0, 400 * F)) - 200 * F;
            ex = $signed($urandom_range(0, 400 * F)) - 200 * F;
            ey = $signed($urandom_range(0, 400 * F)) - 200 * F;
            r = $urandom_range(0, 50 * F);
          end
        end
      endcase
      set_capsule(sx, sy, ex, ey, r);
      rx_stall_on = (ph % 3 != 1);
      tx_gaps_on = (ph % 4 != 2);
      if (ph == 3) hold_req = 1'b1;
      random_phase(ITEMS_PER_PHASE);
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    lim = 0;
    while (expected_q.size() != 0 && lim < 200_000) begin
      @(posedge clk);
      lim++;
    end
    repeat (300) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d expected transactions never arrived", expected_q.size());
      errors++;
    end
    $display("Covered %0d queries and %0d results over %0d capsule settings,",
             n_queries, n_results, N_RAND_PHASES + 2);
    $display("including extreme coordinates, zero radius, point-like bone and a long stall.");
    if (errors == 0) begin
      $display("tb_capsule_nearest_point_2d_top OK");
    end else begin
      $display("tb_capsule_nearest_point_2d_top NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/cnp_pkg.sv
rtl/core/cnp_in_if.sv
rtl/core/cnp_out_if.sv
rtl/core/cnp_cfg.sv
rtl/core/cnp_div.sv
rtl/core/cnp_sqrt.sv
rtl/core/capsule_nearest_point_2d_top.sv
tb/sv/tb_capsule_nearest_point_2d_top.sv
